@@ hdl/pogc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pogc_pkg
// Shared types and constants of the per-azimuth overload gain control unit.
// ----------------------------------------------------------------------------
package pogc_pkg;

    localparam logic [15:0] RESET_THRESHOLD = 16'hEC54;
    localparam logic [7:0]  RESET_GAIN      = 8'd127;
    localparam logic [3:0]  RESET_HALF      = 4'd5;
    localparam logic [7:0]  RESET_LIMIT     = 8'd3;
    localparam logic [7:0]  RESET_MINIMAL   = 8'd0;
    localparam logic [7:0]  RESET_STEP      = 8'd1;
    localparam logic [7:0]  COUNT_MAX       = 8'hFF;

    typedef enum logic [2:0] {
        REG_THRESHOLD = 3'd0,
        REG_HALF      = 3'd1,
        REG_LIMIT     = 3'd2,
        REG_NOMINAL   = 3'd3,
        REG_MINIMAL   = 3'd4,
        REG_STEP      = 3'd5
    } reg_index_t;

    typedef struct packed {
        logic [15:0] threshold;
        logic [3:0]  half_width;
        logic [7:0]  limit;
        logic [7:0]  nominal;
        logic [7:0]  minimal;
        logic [7:0]  step;
    } cfg_t;

    typedef struct packed {
        logic [15:0] azimuth;
        logic        overloaded;
    } job_t;

    typedef struct packed {
        logic [7:0] gain_value;
        logic [9:0] target_line;
    } result_t;

    typedef struct packed {
        logic [7:0] count;
        logic       mark;
        logic [7:0] gain;
    } line_state_t;

    typedef struct packed {
        logic clearing;
        logic busy;
    } back_status_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_SETUP,
        ST_HREAD,
        ST_HWRITE,
        ST_CREAD,
        ST_CWRITE,
        ST_NREAD,
        ST_NCHECK
    } back_state_t;

endpackage

@@ hdl/pogc_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pogc_fifo
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module pogc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [AW:0]      count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == (AW+1)'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= din;
        end
    end

endmodule

@@ hdl/pogc_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pogc_front
// Sample front end: tracks the overload flag of the running line and queues
// one job per line end.
// ----------------------------------------------------------------------------
module pogc_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [15:0]       sample,
    input  logic [15:0]       azimuth,
    input  logic              last_in_line,
    input  logic [15:0]       threshold,
    output logic              job_push,
    output pogc_pkg::job_t    job
);

    logic ovl_reg, ovl_next;
    logic hit;

    assign hit            = (sample > threshold);
    assign job_push       = accept && last_in_line;
    assign job.azimuth    = azimuth;
    assign job.overloaded = ovl_reg || hit;

    always_comb
    begin
        ovl_next = ovl_reg;
        if (accept)
        begin
            // drop the flag at every line end
            ovl_next = last_in_line ? 1'b0 : (ovl_reg || hit);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovl_reg <= 1'b0;
        end
        else
        begin
            ovl_reg <= ovl_next;
        end
    end

endmodule

@@ hdl/pogc_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pogc_back
// Line-end engine: derives the line index, walks the window over the line
// state if overloaded, cleans the trailing line, emits the next line's gain.
// ----------------------------------------------------------------------------
module pogc_back #(
    parameter int NUM_LINES        = 1024,
    parameter int AZIMUTH_PER_LINE = 4
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   job_empty,
    input  pogc_pkg::job_t         job,
    output logic                   job_pop,
    input  pogc_pkg::cfg_t         cfg,
    input  logic                   out_full,
    output logic                   out_push,
    output pogc_pkg::result_t      out_item,
    output pogc_pkg::back_status_t status
);

    localparam int LW      = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;
    localparam int SW      = LW + 2;
    localparam int SHIFT_A = 16 + $clog2(AZIMUTH_PER_LINE);
    localparam int SHIFT_N = 16 + $clog2(NUM_LINES);

    // rounded-up reciprocals; exact quotients for every 16-bit dividend
    localparam logic [63:0] RECIP_A =
        ((64'd1 << SHIFT_A) + AZIMUTH_PER_LINE - 1) / AZIMUTH_PER_LINE;
    localparam logic [63:0] RECIP_N =
        ((64'd1 << SHIFT_N) + NUM_LINES - 1) / NUM_LINES;

    localparam logic [17:0]          MUL_A    = 18'(RECIP_A);
    localparam logic [17:0]          MUL_N    = 18'(RECIP_N);
    localparam logic [31:0]          RING_W   = 32'(NUM_LINES);
    localparam logic signed [SW-1:0] RING_S   = SW'(NUM_LINES);
    localparam logic [LW-1:0]        LAST_IDX = LW'(NUM_LINES - 1);

    pogc_pkg::line_state_t mem [NUM_LINES];
    pogc_pkg::line_state_t rd_data_reg;

    pogc_pkg::back_state_t state_reg, state_next;
    logic [15:0]     shift_reg, shift_next;
    logic [15:0]     quo_reg, quo_next;
    logic [1:0]      div_cnt_reg, div_cnt_next;
    logic            ovl_reg, ovl_next;
    logic [LW-1:0]   line_reg, line_next;
    logic [LW-1:0]   idx_reg, idx_next;
    logic [LW-1:0]   clean_reg, clean_next;
    logic [4:0]      walk_reg, walk_next;
    logic [LW-1:0]   clr_addr_reg, clr_addr_next;
    logic [7:0]      last_sent_reg, last_sent_next;

    logic                  mem_we;
    logic [LW-1:0]         mem_waddr;
    pogc_pkg::line_state_t mem_wdata;

    // line index arithmetic
    logic [33:0] quo_a, quo_n;
    logic [31:0] ring_prod;
    logic [15:0] ring_rem;

    // window bounds
    logic signed [SW-1:0] s0, s1, s2, c0, c1, c2;
    logic [LW-1:0]        next_line, idx_inc;
    logic [LW+9:0]        next_ext;

    // hit arithmetic
    logic [7:0] cnt_inc, gain_red;
    logic [8:0] floor9;

    assign quo_a     = ({18'd0, shift_reg} * {16'd0, MUL_A}) >> SHIFT_A;
    assign quo_n     = ({18'd0, shift_reg} * {16'd0, MUL_N}) >> SHIFT_N;
    assign ring_prod = {16'd0, quo_reg} * RING_W;
    assign ring_rem  = shift_reg - ring_prod[15:0];

    always_comb
    begin
        s0 = $signed({2'b00, line_reg}) - $signed(SW'(cfg.half_width));
        s1 = (s0 < 0) ? s0 + RING_S : s0;
        s2 = (s1 < 0) ? s1 + RING_S : s1;
        c0 = s0 - $signed(SW'(1));
        c1 = (c0 < 0) ? c0 + RING_S : c0;
        c2 = (c1 < 0) ? c1 + RING_S : c1;
    end

    assign next_line = (line_reg == LAST_IDX) ? '0 : line_reg + 1'b1;
    assign idx_inc   = (idx_reg == LAST_IDX) ? '0 : idx_reg + 1'b1;
    assign next_ext  = {10'd0, next_line};

    assign cnt_inc  = (rd_data_reg.count != pogc_pkg::COUNT_MAX) ?
                      rd_data_reg.count + 8'd1 : rd_data_reg.count;
    assign floor9   = {1'b0, cfg.minimal} + {1'b0, cfg.step};
    assign gain_red = ({1'b0, rd_data_reg.gain} <= floor9) ?
                      cfg.minimal : rd_data_reg.gain - cfg.step;

    assign out_item.gain_value  = rd_data_reg.gain;
    assign out_item.target_line = next_ext[9:0];

    assign status.clearing = (state_reg == pogc_pkg::ST_CLEAR);
    assign status.busy     = (state_reg != pogc_pkg::ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        shift_next     = shift_reg;
        quo_next       = quo_reg;
        div_cnt_next   = div_cnt_reg;
        ovl_next       = ovl_reg;
        line_next      = line_reg;
        idx_next       = idx_reg;
        clean_next     = clean_reg;
        walk_next      = walk_reg;
        clr_addr_next  = clr_addr_reg;
        last_sent_next = last_sent_reg;
        job_pop        = 1'b0;
        out_push       = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = idx_reg;
        mem_wdata      = rd_data_reg;

        unique case (state_reg)
            pogc_pkg::ST_CLEAR:
            begin
                mem_we          = 1'b1;
                mem_waddr       = clr_addr_reg;
                mem_wdata.count = '0;
                mem_wdata.mark  = 1'b0;
                mem_wdata.gain  = pogc_pkg::RESET_GAIN;
                clr_addr_next   = clr_addr_reg + 1'b1;
                if (clr_addr_reg == LAST_IDX)
                begin
                    state_next = pogc_pkg::ST_IDLE;
                end
            end
            pogc_pkg::ST_IDLE:
            begin
                if (!job_empty)
                begin
                    job_pop      = 1'b1;
                    shift_next   = job.azimuth;
                    ovl_next     = job.overloaded;
                    div_cnt_next = '0;
                    state_next   = pogc_pkg::ST_DIV;
                end
            end
            pogc_pkg::ST_DIV:
            begin
                // divide by the azimuth span, then by the ring, then take the remainder
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == 2'd0)
                begin
                    shift_next = quo_a[15:0];
                end
                else if (div_cnt_reg == 2'd1)
                begin
                    quo_next = quo_n[15:0];
                end
                else
                begin
                    line_next  = ring_rem[LW-1:0];
                    state_next = pogc_pkg::ST_SETUP;
                end
            end
            pogc_pkg::ST_SETUP:
            begin
                clean_next = c2[LW-1:0];
                walk_next  = '0;
                if (ovl_reg)
                begin
                    idx_next   = s2[LW-1:0];
                    state_next = pogc_pkg::ST_HREAD;
                end
                else
                begin
                    idx_next   = c2[LW-1:0];
                    state_next = pogc_pkg::ST_CREAD;
                end
            end
            pogc_pkg::ST_HREAD:
            begin
                state_next = pogc_pkg::ST_HWRITE;
            end
            pogc_pkg::ST_HWRITE:
            begin
                if (!rd_data_reg.mark)
                begin
                    mem_we          = 1'b1;
                    mem_wdata.count = cnt_inc;
                    mem_wdata.mark  = 1'b1;
                    mem_wdata.gain  = (cnt_inc > cfg.limit) ? gain_red : rd_data_reg.gain;
                end
                if (walk_reg == {cfg.half_width, 1'b0})
                begin
                    idx_next   = clean_reg;
                    state_next = pogc_pkg::ST_CREAD;
                end
                else
                begin
                    walk_next  = walk_reg + 1'b1;
                    idx_next   = idx_inc;
                    state_next = pogc_pkg::ST_HREAD;
                end
            end
            pogc_pkg::ST_CREAD:
            begin
                state_next = pogc_pkg::ST_CWRITE;
            end
            pogc_pkg::ST_CWRITE:
            begin
                mem_we         = 1'b1;
                mem_wdata.mark = 1'b0;
                if (!rd_data_reg.mark)
                begin
                    mem_wdata.count = '0;
                    mem_wdata.gain  = cfg.nominal;
                end
                idx_next   = next_line;
                state_next = pogc_pkg::ST_NREAD;
            end
            pogc_pkg::ST_NREAD:
            begin
                state_next = pogc_pkg::ST_NCHECK;
            end
            pogc_pkg::ST_NCHECK:
            begin
                if (rd_data_reg.gain == last_sent_reg)
                begin
                    state_next = pogc_pkg::ST_IDLE;
                end
                else if (!out_full)
                begin
                    out_push       = 1'b1;
                    last_sent_next = rd_data_reg.gain;
                    state_next     = pogc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pogc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pogc_pkg::ST_CLEAR;
            clr_addr_reg  <= '0;
            last_sent_reg <= pogc_pkg::RESET_GAIN;
            div_cnt_reg   <= '0;
            ovl_reg       <= 1'b0;
            walk_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            last_sent_reg <= last_sent_next;
            div_cnt_reg   <= div_cnt_next;
            ovl_reg       <= ovl_next;
            walk_reg      <= walk_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        quo_reg   <= quo_next;
        line_reg  <= line_next;
        idx_reg   <= idx_next;
        clean_reg <= clean_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[idx_reg];
    end

endmodule

@@ hdl/per_azimuth_overload_gain_control_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_azimuth_overload_gain_control_unit
// Takes one sample per cycle while the line-end queue has room and no memory
// sweep runs. Each line end takes the back engine through pop, three divide
// steps, setup, a read and a write per line-state access (a window walk only
// for an overloaded line) and a read and check of the next line's gain, which
// is queued only if it differs from the last one sent; a full result queue
// stalls it. Full is high during the sweep of line-state memory after reset.
// ----------------------------------------------------------------------------
module per_azimuth_overload_gain_control_unit #(
    parameter int NUM_LINES        = 1024,
    parameter int AZIMUTH_PER_LINE = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [15:0] sample,
    input  logic [15:0] azimuth,
    input  logic        last_in_line,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  gain_value,
    output logic [9:0]  target_line,
    input  logic        wr_en,
    input  logic [2:0]  wr_index,
    input  logic [15:0] wr_data
);

    localparam int JOB_W = $bits(pogc_pkg::job_t);
    localparam int RES_W = $bits(pogc_pkg::result_t);

    pogc_pkg::cfg_t         cfg_reg, cfg_next;
    pogc_pkg::job_t         front_job, back_job;
    pogc_pkg::result_t      back_item, out_item;
    pogc_pkg::back_status_t back_status;

    logic accept;
    logic job_push, job_full, job_empty, job_pop;
    logic out_push, out_full;

    assign full   = job_full || back_status.clearing;
    assign accept = push && !full;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (pogc_pkg::reg_index_t'(wr_index))
                pogc_pkg::REG_THRESHOLD: cfg_next.threshold  = wr_data;
                pogc_pkg::REG_HALF:      cfg_next.half_width = wr_data[3:0];
                pogc_pkg::REG_LIMIT:     cfg_next.limit      = wr_data[7:0];
                pogc_pkg::REG_NOMINAL:   cfg_next.nominal    = wr_data[7:0];
                pogc_pkg::REG_MINIMAL:   cfg_next.minimal    = wr_data[7:0];
                pogc_pkg::REG_STEP:      cfg_next.step       = wr_data[7:0];
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.threshold  <= pogc_pkg::RESET_THRESHOLD;
            cfg_reg.half_width <= pogc_pkg::RESET_HALF;
            cfg_reg.limit      <= pogc_pkg::RESET_LIMIT;
            cfg_reg.nominal    <= pogc_pkg::RESET_GAIN;
            cfg_reg.minimal    <= pogc_pkg::RESET_MINIMAL;
            cfg_reg.step       <= pogc_pkg::RESET_STEP;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    pogc_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .sample       (sample),
        .azimuth      (azimuth),
        .last_in_line (last_in_line),
        .threshold    (cfg_reg.threshold),
        .job_push     (job_push),
        .job          (front_job)
    );

    pogc_fifo #(
        .WIDTH (JOB_W),
        .DEPTH (4)
    ) u_job_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (job_push),
        .din   (front_job),
        .full  (job_full),
        .pop   (job_pop),
        .dout  (back_job),
        .empty (job_empty)
    );

    pogc_back #(
        .NUM_LINES        (NUM_LINES),
        .AZIMUTH_PER_LINE (AZIMUTH_PER_LINE)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_empty (job_empty),
        .job       (back_job),
        .job_pop   (job_pop),
        .cfg       (cfg_reg),
        .out_full  (out_full),
        .out_push  (out_push),
        .out_item  (back_item),
        .status    (back_status)
    );

    pogc_fifo #(
        .WIDTH (RES_W),
        .DEPTH (2)
    ) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (out_push),
        .din   (back_item),
        .full  (out_full),
        .pop   (pop),
        .dout  (out_item),
        .empty (empty)
    );

    assign gain_value  = out_item.gain_value;
    assign target_line = out_item.target_line;

    // a line end must never be offered to a full job queue
    a_job_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        job_push |-> !job_full)
        else $error("line-end job pushed into full queue");

    // the engine must never emit into a full result queue
    a_out_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        out_push |-> !out_full)
        else $error("result pushed into full queue");

    // no job is taken and no result is emitted while the memory sweep is running
    a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        back_status.clearing |-> !job_pop && !out_push)
        else $error("engine active during memory sweep");

    // a popped job leaves the engine busy on the next cycle
    a_busy_after_pop: assert property (@(posedge clk) disable iff (!rst_n)
        job_pop |=> back_status.busy)
        else $error("engine idle right after taking a job");

endmodule
